/* design/csrs_pkg.sv */
// Package for the composite sync raster scanner: item type, color codes,
// sizes and reset constants. No dependencies.
package csrs_pkg;

   localparam int COORD_BITS_DEFAULT = 11;
   localparam int COUNT_BITS_DEFAULT = 8;
   localparam int THRESH_BITS        = 8;
   localparam int THRESH_RESET       = 35;
   localparam int EXTENT_RESET       = 100;

   typedef enum logic [1:0] {
      COLOR_BLACK = 2'd0,
      COLOR_WHITE = 2'd1,
      COLOR_HSYNC = 2'd2,
      COLOR_VSYNC = 2'd3
   } color_type;

   // One validly driven edge as held in the input register
   typedef struct packed {
      logic sync_level;
      logic data_level;
   } item_type;

endpackage

/* design/csrs_ifs.sv */
// Channel interfaces of the raster scanner: request, response and register write.
// Depends on csrs_pkg for the register width.
interface csrs_req_if;
   logic valid;
   logic ready;
   logic sync_level;
   logic data_level;
   logic lines_valid;

   modport source (output valid, output sync_level, output data_level,
                   output lines_valid, input ready);
   modport sink   (input valid, input sync_level, input data_level,
                   input lines_valid, output ready);
endinterface

interface csrs_rsp_if #(
   parameter int COORD_BITS = csrs_pkg::COORD_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;
   logic [1:0]            color_class;
   logic [COORD_BITS-1:0] extent_x;
   logic [COORD_BITS-1:0] extent_y;

   modport source (output valid, output pixel_x, output pixel_y, output color_class,
                   output extent_x, output extent_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, input color_class,
                   input extent_x, input extent_y, output ready);
endinterface

interface csrs_csr_if;
   logic                             valid;
   logic                             ready;
   logic [csrs_pkg::THRESH_BITS-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* design/csrs_scan_core.sv */
// Scan state of the raster scanner and the per-edge update logic.
// Depends on csrs_pkg.
module csrs_scan_core #(
   parameter int COORD_BITS = csrs_pkg::COORD_BITS_DEFAULT,
   parameter int COUNT_BITS = csrs_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step_en,
   input  csrs_pkg::item_type               item,
   input  logic [csrs_pkg::THRESH_BITS-1:0] threshold,
   output logic [COORD_BITS-1:0]            pixel_x,
   output logic [COORD_BITS-1:0]            pixel_y,
   output logic [1:0]                       color_class,
   output logic [COORD_BITS-1:0]            extent_x,
   output logic [COORD_BITS-1:0]            extent_y
);
   import csrs_pkg::*;

   localparam int CMP_BITS = (COUNT_BITS > THRESH_BITS) ? COUNT_BITS : THRESH_BITS;

   logic                  in_hsync_ff, in_hsync_in;
   logic                  in_vsync_ff, in_vsync_in;
   logic [COORD_BITS-1:0] scan_x_ff, scan_x_in;
   logic [COORD_BITS-1:0] scan_y_ff, scan_y_in;
   logic [COUNT_BITS-1:0] sync_count_ff, sync_count_in;
   logic [COORD_BITS-1:0] max_x_ff, max_x_in;
   logic [COORD_BITS-1:0] max_y_ff, max_y_in;

   logic [COORD_BITS-1:0] scan_y_inc;
   logic [COUNT_BITS-1:0] sync_count_inc;
   logic                  thresh_hit;
   logic [COORD_BITS-1:0] scan_x_mid;
   color_type             color;

   assign scan_y_inc     = (&scan_y_ff) ? scan_y_ff : scan_y_ff + 1'b1;
   assign sync_count_inc = (&sync_count_ff) ? sync_count_ff : sync_count_ff + 1'b1;
   assign thresh_hit     = CMP_BITS'(sync_count_inc) > CMP_BITS'(threshold);

   always_comb begin
      in_hsync_in   = in_hsync_ff;
      in_vsync_in   = in_vsync_ff;
      scan_x_mid    = scan_x_ff;
      scan_y_in     = scan_y_ff;
      sync_count_in = sync_count_ff;
      max_y_in      = max_y_ff;
      priority if (item.sync_level && !in_hsync_ff) begin
         // rising sync: next line
         in_hsync_in   = 1'b1;
         scan_x_mid    = '0;
         scan_y_in     = scan_y_inc;
         sync_count_in = '0;
         if (scan_y_inc > max_y_ff) begin
            max_y_in = scan_y_inc;
         end
      end else if (item.sync_level) begin
         sync_count_in = sync_count_inc;
         if (thresh_hit) begin
            if (!in_vsync_ff) begin
               scan_x_mid  = '0;
               scan_y_in   = '0;
               in_vsync_in = 1'b1;
            end else if (scan_x_ff >= max_x_ff) begin
               scan_x_mid = '0;
               scan_y_in  = scan_y_inc;
            end
         end
      end else if (in_hsync_ff) begin
         in_hsync_in = 1'b0;
         if (in_vsync_ff) begin
            in_vsync_in = 1'b0;
            scan_x_mid  = '0;
            scan_y_in   = scan_y_inc;
         end
      end else begin
         // sync low outside sync: only the column advances
      end
   end

   always_comb begin
      priority if (in_vsync_in) begin
         color = COLOR_VSYNC;
      end else if (in_hsync_in) begin
         color = COLOR_HSYNC;
      end else if (item.data_level) begin
         color = COLOR_WHITE;
      end else begin
         color = COLOR_BLACK;
      end
   end

   // column advance after the result position is taken
   assign scan_x_in = (&scan_x_mid) ? scan_x_mid : scan_x_mid + 1'b1;
   assign max_x_in  = (scan_x_in > max_x_ff) ? scan_x_in : max_x_ff;

   assign pixel_x     = scan_x_mid;
   assign pixel_y     = scan_y_in;
   assign color_class = color;
   assign extent_x    = max_x_in;
   assign extent_y    = max_y_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_hsync_ff   <= 1'b0;
         in_vsync_ff   <= 1'b0;
         scan_x_ff     <= '0;
         scan_y_ff     <= '0;
         sync_count_ff <= '0;
         max_x_ff      <= COORD_BITS'(EXTENT_RESET);
         max_y_ff      <= COORD_BITS'(EXTENT_RESET);
      end else if (step_en) begin
         in_hsync_ff   <= in_hsync_in;
         in_vsync_ff   <= in_vsync_in;
         scan_x_ff     <= scan_x_in;
         scan_y_ff     <= scan_y_in;
         sync_count_ff <= sync_count_in;
         max_x_ff      <= max_x_in;
         max_y_ff      <= max_y_in;
      end
   end

endmodule

/* design/csrs_rsp_reg.sv */
// Response register of the raster scanner: holds one result until taken.
// Depends on csrs_pkg and csrs_rsp_if.
module csrs_rsp_reg #(
   parameter int COORD_BITS = csrs_pkg::COORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic [COORD_BITS-1:0] pixel_x,
   input  logic [COORD_BITS-1:0] pixel_y,
   input  logic [1:0]            color_class,
   input  logic [COORD_BITS-1:0] extent_x,
   input  logic [COORD_BITS-1:0] extent_y,
   output logic                  space,
   csrs_rsp_if.source            rsp_bus
);
   import csrs_pkg::*;

   logic                  valid_ff;
   logic [COORD_BITS-1:0] pixel_x_ff, pixel_y_ff, extent_x_ff, extent_y_ff;
   logic [1:0]            color_ff;

   assign space = !valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (space) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load && space) begin
         pixel_x_ff  <= pixel_x;
         pixel_y_ff  <= pixel_y;
         color_ff    <= color_class;
         extent_x_ff <= extent_x;
         extent_y_ff <= extent_y;
      end
   end

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.pixel_x     = pixel_x_ff;
   assign rsp_bus.pixel_y     = pixel_y_ff;
   assign rsp_bus.color_class = color_ff;
   assign rsp_bus.extent_x    = extent_x_ff;
   assign rsp_bus.extent_y    = extent_y_ff;

endmodule

/* design/composite_sync_raster_scanner_core.sv */
// Top level of the composite sync raster scanner.
// Depends on csrs_pkg, csrs_ifs, csrs_scan_core and csrs_rsp_reg.
//
//   channel   dir  payload                                         accepted when
//   req_bus   in   sync_level, data_level, lines_valid             valid && ready
//   rsp_bus   out  pixel_x, pixel_y, color_class, extent_x/y       valid && ready
//   csr_bus   in   data (vsync threshold)                          valid && ready
//
// One request per cycle sustained while the response is not stalled; a result
// passes through the input register, then the response register. Requests with
// lines_valid low are taken and dropped. Reset clears the scan state, sets
// extents to 100 and the threshold to 35. A stalled response holds the
// pipeline; req_bus.ready drops only when both registers are full.
module composite_sync_raster_scanner_core #(
   parameter int COORD_BITS = csrs_pkg::COORD_BITS_DEFAULT,
   parameter int COUNT_BITS = csrs_pkg::COUNT_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   csrs_req_if.sink   req_bus,
   csrs_rsp_if.source rsp_bus,
   csrs_csr_if.sink   csr_bus
);
   import csrs_pkg::*;

   logic                   in_valid_ff;
   item_type               item_ff;
   logic [THRESH_BITS-1:0] threshold_ff;
   logic                   space;
   logic                   fire;
   logic                   req_take;

   logic [COORD_BITS-1:0]  pixel_x, pixel_y, extent_x, extent_y;
   logic [1:0]             color_class;

   assign fire           = in_valid_ff && space;
   assign req_bus.ready  = !in_valid_ff || fire;
   assign req_take       = req_bus.valid && req_bus.ready;
   assign csr_bus.ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid && req_bus.lines_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.sync_level <= req_bus.sync_level;
         item_ff.data_level <= req_bus.data_level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_BITS'(THRESH_RESET);
      end else if (csr_bus.valid) begin
         threshold_ff <= csr_bus.data;
      end
   end

   csrs_scan_core #(
      .COORD_BITS (COORD_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .step_en     (fire),
      .item        (item_ff),
      .threshold   (threshold_ff),
      .pixel_x     (pixel_x),
      .pixel_y     (pixel_y),
      .color_class (color_class),
      .extent_x    (extent_x),
      .extent_y    (extent_y)
   );

   csrs_rsp_reg #(
      .COORD_BITS (COORD_BITS)
   ) u_rsp (
      .clock       (clock),
      .reset       (reset),
      .load        (in_valid_ff),
      .pixel_x     (pixel_x),
      .pixel_y     (pixel_y),
      .color_class (color_class),
      .extent_x    (extent_x),
      .extent_y    (extent_y),
      .space       (space),
      .rsp_bus     (rsp_bus)
   );

endmodule

/* design/csrs_checker.sv */
// Port-level checks for the raster scanner top, attached by bind.
// Depends on composite_sync_raster_scanner_core.
module csrs_checker #(
   parameter int COORD_BITS = csrs_pkg::COORD_BITS_DEFAULT
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [COORD_BITS-1:0] pixel_x,
   input logic [COORD_BITS-1:0] extent_x,
   input logic [COORD_BITS-1:0] extent_y
);

   // a stalled response holds its position
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pixel_x) && $stable(extent_x))
      else $error("stalled response changed");

   // the pipeline never blocks requests while the response register is empty
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response register");

   // column advance keeps the plotted column within the horizontal extent
   a_x_in_extent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pixel_x <= extent_x)
      else $error("pixel_x beyond extent_x");

   // extents never shrink from one response to the next
   a_extent_grow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=>
         !rsp_valid || (extent_x >= $past(extent_x) && extent_y >= $past(extent_y)))
      else $error("extent decreased");

endmodule

bind composite_sync_raster_scanner_core csrs_checker #(
   .COORD_BITS (COORD_BITS)
) u_csrs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .pixel_x   (rsp_bus.pixel_x),
   .extent_x  (rsp_bus.extent_x),
   .extent_y  (rsp_bus.extent_y)
);
